### hw/rtl/bsd_pkg.sv
// Shared types, constants and table math for the single-bin Bloch DFT core.
package bsd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int TWID_W      = 16;
  localparam int CHUNK_W     = 16;
  localparam int RECIP_W     = 32;
  localparam int PHASE_W     = 32;
  localparam int SCALE_SHIFT = 47;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [TWID_W-1:0]      SINE_PEAK = 16'd32767;
  localparam logic [SAMPLE_BITS-1:0] SAT_MAX   = 16'h7FFF;
  localparam logic [SAMPLE_BITS-1:0] SAT_MIN   = 16'h8000;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] TAYLOR_DEN [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_K_X         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_K_Y         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP_CELLS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 3'd7;

  typedef struct packed {
    logic signed [15:0] k_x;
    logic signed [15:0] k_y;
    logic [6:0]         cells_x;
    logic [6:0]         cells_y;
    logic [31:0]        recip_x;
    logic [31:0]        recip_y;
    logic [31:0]        recip_cells;
    logic [4:0]         point_count;
  } cfg_t;

  // one queued request from the front to the back
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] amp_re;
    logic signed [SAMPLE_BITS-1:0] amp_im;
    logic [PHASE_W-1:0]            phase;
    logic                          used;
    logic                          last;
  } entry_t;

  // accumulator width: product, sum of two products, one frame of cells
  function automatic int acc_width(input int max_cells);
    return 2 * SAMPLE_BITS + 1 + 2 * $clog2(max_cells);
  endfunction

  // quarter-wave sine entry, Q15, from a fixed-point Taylor series
  function automatic logic [TWID_W-1:0] sine_entry(input int j, input int tab_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] e;
    x  = (HALF_PI_Q30 * 64'(j)) >> tab_bits;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    for (int n = 0; n < 6; n++) begin
      t = Q30_ONE - ((x2 * t) >> 30) / TAYLOR_DEN[n];
    end
    s = (x * t) >> 30;
    e = (s * 64'(SINE_PEAK) + (64'd1 << 29)) >> 30;
    if (e > 64'(SINE_PEAK)) begin
      e = 64'(SINE_PEAK);
    end
    return e[TWID_W-1:0];
  endfunction

endpackage

### hw/rtl/bsd_front.sv
// Front end: accepts amplitudes, tracks point/cell position and phase, queues work.
module bsd_front import bsd_pkg::*; #(
  parameter int MAX_CELLS = 64,
  parameter int MAX_POINT = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] amp_re_i,
  input  logic signed [SAMPLE_BITS-1:0] amp_im_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output entry_t                        entry_o
);

  localparam int PIW = (MAX_POINT > 1) ? $clog2(MAX_POINT) : 1;
  localparam int PCW = PIW + 1;
  localparam int CIW = $clog2(MAX_CELLS);
  localparam int CCW = CIW + 1;

  logic [PIW-1:0]     point_idx_q;
  logic [CIW-1:0]     col_idx_q;
  logic [CIW-1:0]     row_idx_q;
  logic [PHASE_W-1:0] col_phase_q;
  logic [PHASE_W-1:0] row_phase_q;

  logic [PCW-1:0]     pc;
  logic [CCW-1:0]     ex;
  logic [CCW-1:0]     ey;
  logic [PCW-1:0]     pt_inc;
  logic [CCW-1:0]     col_inc;
  logic [CCW-1:0]     row_inc;
  logic               pt_wrap;
  logic               col_wrap;
  logic               row_wrap;
  logic               accept;
  logic               last;
  logic [PHASE_W-1:0] kx_ext;
  logic [PHASE_W-1:0] ky_ext;
  logic [PHASE_W-1:0] step_x;
  logic [PHASE_W-1:0] step_y;

  // extents clamped to [1, max]
  always_comb begin
    if (cfg_i.point_count == '0) begin
      pc = PCW'(1);
    end else if (32'(cfg_i.point_count) > MAX_POINT) begin
      pc = PCW'(MAX_POINT);
    end else begin
      pc = PCW'(cfg_i.point_count);
    end
    if (cfg_i.cells_x == '0) begin
      ex = CCW'(1);
    end else if (32'(cfg_i.cells_x) > MAX_CELLS) begin
      ex = CCW'(MAX_CELLS);
    end else begin
      ex = CCW'(cfg_i.cells_x);
    end
    if (cfg_i.cells_y == '0) begin
      ey = CCW'(1);
    end else if (32'(cfg_i.cells_y) > MAX_CELLS) begin
      ey = CCW'(MAX_CELLS);
    end else begin
      ey = CCW'(cfg_i.cells_y);
    end
  end

  assign pt_inc   = PCW'(point_idx_q) + PCW'(1);
  assign col_inc  = CCW'(col_idx_q) + CCW'(1);
  assign row_inc  = CCW'(row_idx_q) + CCW'(1);
  // >= so a counter left above a shrunken extent wraps at its next advance
  assign pt_wrap  = pt_inc >= pc;
  assign col_wrap = col_inc >= ex;
  assign row_wrap = row_inc >= ey;
  assign last     = pt_wrap && col_wrap && row_wrap;

  // phase step per cell, mod 2^32
  assign kx_ext = {{(PHASE_W-16){cfg_i.k_x[15]}}, cfg_i.k_x};
  assign ky_ext = {{(PHASE_W-16){cfg_i.k_y[15]}}, cfg_i.k_y};
  assign step_x = kx_ext * cfg_i.recip_x;
  assign step_y = ky_ext * cfg_i.recip_y;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign entry_o.amp_re = amp_re_i;
  assign entry_o.amp_im = amp_im_i;
  assign entry_o.phase  = col_phase_q + row_phase_q;
  assign entry_o.used   = (point_idx_q == '0);
  assign entry_o.last   = last;
  // elements off point index 0 only matter when they close the frame
  assign push_o = accept && (entry_o.used || last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_idx_q <= '0;
      col_idx_q   <= '0;
      row_idx_q   <= '0;
      col_phase_q <= '0;
      row_phase_q <= '0;
    end else if (accept) begin
      if (!pt_wrap) begin
        point_idx_q <= pt_inc[PIW-1:0];
      end else begin
        point_idx_q <= '0;
        if (!col_wrap) begin
          col_idx_q   <= col_inc[CIW-1:0];
          col_phase_q <= col_phase_q + step_x;
        end else begin
          col_idx_q   <= '0;
          col_phase_q <= '0;
          if (!row_wrap) begin
            row_idx_q   <= row_inc[CIW-1:0];
            row_phase_q <= row_phase_q + step_y;
          end else begin
            row_idx_q   <= '0;
            row_phase_q <= '0;
          end
        end
      end
    end
  end

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last |=> point_idx_q == '0 && col_idx_q == '0 && row_idx_q == '0
                       && col_phase_q == '0 && row_phase_q == '0)
    else $error("position counters not cleared after frame end");

endmodule

### hw/rtl/bsd_queue.sv
// Short request queue between the front end and the accumulate back end.
module bsd_queue import bsd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t entry_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q;
  logic [PTR_W-1:0]   rd_ptr_q;
  logic [CNT_W-1:0]   count_q;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("request pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("request popped from empty queue");

endmodule

### hw/rtl/bsd_back.sv
// Back end: twiddle lookup, complex multiply and frame accumulation.
module bsd_back import bsd_pkg::*; #(
  parameter int  MAX_CELLS  = 64,
  parameter int  TABLE_BITS = 10,
  localparam int ACCW       = acc_width(MAX_CELLS)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  entry_t                 entry_i,
  output logic                   pop_o,
  input  logic                   fin_busy_i,
  output logic                   fin_start_o,
  output logic signed [ACCW-1:0] fin_re_o,
  output logic signed [ACCW-1:0] fin_im_o
);

  localparam int TAB_LEN = 1 << TABLE_BITS;
  localparam int PROD_W  = SAMPLE_BITS + TWID_W;

  typedef logic [TWID_W-1:0] rom_t [TAB_LEN];

  function automatic rom_t build_rom();
    rom_t r;
    for (int j = 0; j < TAB_LEN; j++) begin
      r[j] = sine_entry(j, TABLE_BITS);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // lookup request
  logic [1:0]            quad;
  logic [TABLE_BITS-1:0] tj;
  logic [TABLE_BITS-1:0] tjn;
  logic [TABLE_BITS-1:0] sin_addr;
  logic [TABLE_BITS-1:0] cos_addr;

  // stage 1: table read
  logic                          s1_vld_q;
  logic                          s1_last_q;
  logic                          s1_used_q;
  logic signed [SAMPLE_BITS-1:0] s1_re_q;
  logic signed [SAMPLE_BITS-1:0] s1_im_q;
  logic [TWID_W-1:0]             s1_sin_raw_q;
  logic [TWID_W-1:0]             s1_cos_raw_q;
  logic                          s1_sin_max_q;
  logic                          s1_cos_max_q;
  logic                          s1_sin_neg_q;
  logic                          s1_cos_neg_q;
  logic [TWID_W-1:0]             sin_mag;
  logic [TWID_W-1:0]             cos_mag;
  logic signed [TWID_W-1:0]      sin_val;
  logic signed [TWID_W-1:0]      cos_val;

  // stage 2: products
  logic                     s2_vld_q;
  logic                     s2_last_q;
  logic                     s2_used_q;
  logic signed [PROD_W-1:0] s2_ac_q;
  logic signed [PROD_W-1:0] s2_bs_q;
  logic signed [PROD_W-1:0] s2_bc_q;
  logic signed [PROD_W-1:0] s2_as_q;

  // stage 3: accumulate
  logic signed [ACCW-1:0] acc_re_q;
  logic signed [ACCW-1:0] acc_im_q;
  logic signed [ACCW-1:0] add_re;
  logic signed [ACCW-1:0] add_im;
  logic signed [ACCW-1:0] sum_re;
  logic signed [ACCW-1:0] sum_im;
  logic                   fin_start_q;
  logic signed [ACCW-1:0] fin_re_q;
  logic signed [ACCW-1:0] fin_im_q;

  // hold the queue while a frame end is in flight or being scaled
  assign pop_o = q_valid_i && !fin_busy_i && !fin_start_q
              && !(s1_vld_q && s1_last_q) && !(s2_vld_q && s2_last_q);

  // odd quadrants read the table mirrored; cos is sin a quarter turn later
  assign quad     = entry_i.phase[PHASE_W-1 -: 2];
  assign tj       = entry_i.phase[PHASE_W-3 -: TABLE_BITS];
  assign tjn      = '0 - tj;
  assign sin_addr = quad[0] ? tjn : tj;
  assign cos_addr = quad[0] ? tj : tjn;

  always_ff @(posedge clk_i) begin
    s1_last_q    <= entry_i.last;
    s1_used_q    <= entry_i.used;
    s1_re_q      <= entry_i.amp_re;
    s1_im_q      <= entry_i.amp_im;
    s1_sin_raw_q <= SINE_ROM[sin_addr];
    s1_cos_raw_q <= SINE_ROM[cos_addr];
    s1_sin_max_q <= quad[0] && (tj == '0);
    s1_cos_max_q <= !quad[0] && (tj == '0);
    s1_sin_neg_q <= quad[1];
    s1_cos_neg_q <= quad[1] ^ quad[0];
  end

  always_comb begin
    sin_mag = s1_sin_max_q ? SINE_PEAK : s1_sin_raw_q;
    cos_mag = s1_cos_max_q ? SINE_PEAK : s1_cos_raw_q;
    sin_val = s1_sin_neg_q ? -$signed(sin_mag) : $signed(sin_mag);
    cos_val = s1_cos_neg_q ? -$signed(cos_mag) : $signed(cos_mag);
  end

  always_ff @(posedge clk_i) begin
    s2_last_q <= s1_last_q;
    s2_used_q <= s1_used_q;
    s2_ac_q   <= s1_re_q * cos_val;
    s2_bs_q   <= s1_im_q * sin_val;
    s2_bc_q   <= s1_im_q * cos_val;
    s2_as_q   <= s1_re_q * sin_val;
  end

  // weight is (cos, -sin)
  always_comb begin
    if (s2_used_q) begin
      add_re = ACCW'(s2_ac_q) + ACCW'(s2_bs_q);
      add_im = ACCW'(s2_bc_q) - ACCW'(s2_as_q);
    end else begin
      add_re = '0;
      add_im = '0;
    end
    sum_re = acc_re_q + add_re;
    sum_im = acc_im_q + add_im;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      acc_re_q    <= '0;
      acc_im_q    <= '0;
      fin_start_q <= 1'b0;
    end else begin
      s1_vld_q    <= pop_o;
      s2_vld_q    <= s1_vld_q;
      fin_start_q <= s2_vld_q && s2_last_q;
      if (s2_vld_q) begin
        if (s2_last_q) begin
          acc_re_q <= '0;
          acc_im_q <= '0;
        end else begin
          acc_re_q <= sum_re;
          acc_im_q <= sum_im;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q && s2_last_q) begin
      fin_re_q <= sum_re;
      fin_im_q <= sum_im;
    end
  end

  assign fin_start_o = fin_start_q;
  assign fin_re_o    = fin_re_q;
  assign fin_im_o    = fin_im_q;

endmodule

### hw/rtl/bsd_finish.sv
// Frame finish: scale by recip_cells over chunked multiplies, round, saturate, output register.
module bsd_finish import bsd_pkg::*; #(
  parameter int  MAX_CELLS = 64,
  localparam int ACCW      = acc_width(MAX_CELLS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [ACCW-1:0]        acc_re_i,
  input  logic signed [ACCW-1:0]        acc_im_i,
  input  logic [RECIP_W-1:0]            recip_cells_i,
  output logic                          busy_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] bloch_re_o,
  output logic signed [SAMPLE_BITS-1:0] bloch_im_o,
  output logic                          clipped_o
);

  localparam int NCH   = (ACCW + CHUNK_W - 1) / CHUNK_W;
  localparam int MW    = NCH * CHUNK_W;
  localparam int PW    = MW + RECIP_W;
  localparam int QW    = PW - SCALE_SHIFT;
  localparam int CNT_W = $clog2(NCH + 1);
  localparam int PPW   = CHUNK_W + RECIP_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_RND  = 2'd2;

  logic [1:0]       state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             neg_re_q;
  logic             neg_im_q;
  logic [MW-1:0]    mag_re_q;
  logic [MW-1:0]    mag_im_q;
  logic [PW-1:0]    prod_re_q;
  logic [PW-1:0]    prod_im_q;
  logic             out_valid_q;
  logic [SAMPLE_BITS-1:0] out_re_q;
  logic [SAMPLE_BITS-1:0] out_im_q;
  logic             out_clip_q;

  logic [ACCW-1:0]  abs_re;
  logic [ACCW-1:0]  abs_im;
  logic [PPW-1:0]   pp_re;
  logic [PPW-1:0]   pp_im;
  logic [PW-1:0]    rnd_re;
  logic [PW-1:0]    rnd_im;
  logic [SAMPLE_BITS:0] sat_re;
  logic [SAMPLE_BITS:0] sat_im;
  logic             out_free;
  logic             out_load;

  // {clip, value}: apply sign and clamp to Q1.15
  function automatic logic [SAMPLE_BITS:0] sat_part(input logic neg, input logic [QW-1:0] q);
    logic [QW-1:0]          lim;
    logic [SAMPLE_BITS-1:0] val;
    logic                   clip;
    lim  = QW'(1) << (SAMPLE_BITS - 1);
    clip = 1'b0;
    if (neg) begin
      if (q > lim) begin
        val  = SAT_MIN;
        clip = 1'b1;
      end else begin
        val = '0 - q[SAMPLE_BITS-1:0];
      end
    end else begin
      if (q > lim - QW'(1)) begin
        val  = SAT_MAX;
        clip = 1'b1;
      end else begin
        val = q[SAMPLE_BITS-1:0];
      end
    end
    return {clip, val};
  endfunction

  assign abs_re = acc_re_i[ACCW-1] ? ACCW'('0 - acc_re_i) : ACCW'(acc_re_i);
  assign abs_im = acc_im_i[ACCW-1] ? ACCW'('0 - acc_im_i) : ACCW'(acc_im_i);

  // top chunk first, so each step is shift-and-add
  assign pp_re = mag_re_q[MW-1 -: CHUNK_W] * recip_cells_i;
  assign pp_im = mag_im_q[MW-1 -: CHUNK_W] * recip_cells_i;

  // round half away from zero on the magnitude
  assign rnd_re = prod_re_q + (PW'(1) << (SCALE_SHIFT - 1));
  assign rnd_im = prod_im_q + (PW'(1) << (SCALE_SHIFT - 1));
  assign sat_re = sat_part(neg_re_q, rnd_re[PW-1:SCALE_SHIFT]);
  assign sat_im = sat_part(neg_im_q, rnd_im[PW-1:SCALE_SHIFT]);

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == ST_RND) && out_free;
  assign busy_o   = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_MUL;
            cnt_q   <= CNT_W'(NCH - 1);
          end
        end
        ST_MUL: begin
          if (cnt_q == '0) begin
            state_q <= ST_RND;
          end else begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end
        ST_RND: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      neg_re_q  <= acc_re_i[ACCW-1];
      neg_im_q  <= acc_im_i[ACCW-1];
      mag_re_q  <= MW'(abs_re);
      mag_im_q  <= MW'(abs_im);
      prod_re_q <= '0;
      prod_im_q <= '0;
    end else if (state_q == ST_MUL) begin
      mag_re_q  <= mag_re_q << CHUNK_W;
      mag_im_q  <= mag_im_q << CHUNK_W;
      prod_re_q <= (prod_re_q << CHUNK_W) + PW'(pp_re);
      prod_im_q <= (prod_im_q << CHUNK_W) + PW'(pp_im);
    end
    if (out_load) begin
      out_re_q   <= sat_re[SAMPLE_BITS-1:0];
      out_im_q   <= sat_im[SAMPLE_BITS-1:0];
      out_clip_q <= sat_re[SAMPLE_BITS] || sat_im[SAMPLE_BITS];
    end
  end

  assign out_valid_o = out_valid_q;
  assign bloch_re_o  = out_re_q;
  assign bloch_im_o  = out_im_q;
  assign clipped_o   = out_clip_q;

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == ST_IDLE)
    else $error("frame finish requested while scaling unit busy");

  a_clip_means_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clipped_o |-> bloch_re_o == SAT_MAX || bloch_re_o == SAT_MIN
                                 || bloch_im_o == SAT_MAX || bloch_im_o == SAT_MIN)
    else $error("clipped flagged without a saturated part");

endmodule

### hw/rtl/bloch_single_bin_dft_core.sv
// Top level of the single-bin 2-D DFT (Bloch momentum projection) core.
//
// Input channel (in_valid_i / in_stall_o): one complex Q1.15 amplitude per
// group element, cell-major (row, then column), point index minor. Only
// point index 0 of each cell contributes. Output channel (out_valid_o /
// out_stall_i): one result per frame, the frame sum times recip_cells / 2^47,
// rounded half away from zero and saturated to Q1.15, with clipped_o set if
// either part hit a rail. Registers are written through cfg_we_i, cfg_idx_i,
// cfg_data_i; the user must write them only while no frame is in progress,
// which the core does not enforce. Within a frame one element is taken per
// cycle while in_stall_o is low. The last element of a frame passes through
// queue pop and table read, multiply, accumulate, scaler load, then three
// 16x32 scaling steps and a round/saturate step on its way to out_valid_o.
// The back end holds the queue at each frame end until the result has been
// scaled; the 4-entry queue keeps taking input meanwhile. Reset restores the
// register defaults and clears the position counters, accumulator, queue and
// output. A stalled result is held in the output register; the scaling unit
// then waits, the queue fills and in_stall_o rises.
module bloch_single_bin_dft_core import bsd_pkg::*; #(
  parameter int MAX_CELLS  = 64,
  parameter int MAX_POINT  = 16,
  parameter int TABLE_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] amp_re_i,
  input  logic signed [SAMPLE_BITS-1:0] amp_im_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] bloch_re_o,
  output logic signed [SAMPLE_BITS-1:0] bloch_im_o,
  output logic                          clipped_o
);

  localparam int ACCW = acc_width(MAX_CELLS);

  cfg_t                   cfg_q;
  logic                   push;
  entry_t                 push_entry;
  logic                   q_full;
  logic                   q_valid;
  entry_t                 pop_entry;
  logic                   pop;
  logic                   fin_busy;
  logic                   fin_start;
  logic signed [ACCW-1:0] fin_re;
  logic signed [ACCW-1:0] fin_im;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.k_x         <= '0;
      cfg_q.k_y         <= '0;
      cfg_q.cells_x     <= 7'd1;
      cfg_q.cells_y     <= 7'd1;
      cfg_q.recip_x     <= '0;
      cfg_q.recip_y     <= '0;
      cfg_q.recip_cells <= '0;
      cfg_q.point_count <= 5'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_K_X:         cfg_q.k_x         <= cfg_data_i[15:0];
        CFG_K_Y:         cfg_q.k_y         <= cfg_data_i[15:0];
        CFG_CELLS_X:     cfg_q.cells_x     <= cfg_data_i[6:0];
        CFG_CELLS_Y:     cfg_q.cells_y     <= cfg_data_i[6:0];
        CFG_RECIP_X:     cfg_q.recip_x     <= cfg_data_i[31:0];
        CFG_RECIP_Y:     cfg_q.recip_y     <= cfg_data_i[31:0];
        CFG_RECIP_CELLS: cfg_q.recip_cells <= cfg_data_i[31:0];
        CFG_POINT_COUNT: cfg_q.point_count <= cfg_data_i[4:0];
        default: begin
        end
      endcase
    end
  end

  bsd_front #(
    .MAX_CELLS (MAX_CELLS),
    .MAX_POINT (MAX_POINT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .amp_re_i   (amp_re_i),
    .amp_im_i   (amp_im_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  bsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (pop_entry)
  );

  bsd_back #(
    .MAX_CELLS  (MAX_CELLS),
    .TABLE_BITS (TABLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .fin_busy_i  (fin_busy),
    .fin_start_o (fin_start),
    .fin_re_o    (fin_re),
    .fin_im_o    (fin_im)
  );

  bsd_finish #(
    .MAX_CELLS (MAX_CELLS)
  ) u_finish (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (fin_start),
    .acc_re_i      (fin_re),
    .acc_im_i      (fin_im),
    .recip_cells_i (cfg_q.recip_cells),
    .busy_o        (fin_busy),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .bloch_re_o    (bloch_re_o),
    .bloch_im_o    (bloch_im_o),
    .clipped_o     (clipped_o)
  );

endmodule
